// ===== hw/rtl/psr_pkg.sv =====
// ---------------------------------------------------------------------------
// psr_pkg : shared types and constants for the sepia / row-flip pixel block
// Payload structs, command codes, sepia coefficients and the divide-by-1000
// reciprocal used by the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

   // mode register codes (3 is unused and behaves as pass-through)
   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_SEPIA  = 2'd1;
   localparam logic [1:0] MODE_MIRROR = 2'd2;

   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // sepia coefficients in thousandths
   localparam logic [9:0] K_RR = 10'd393;
   localparam logic [9:0] K_RG = 10'd769;
   localparam logic [9:0] K_RB = 10'd189;
   localparam logic [9:0] K_GR = 10'd349;
   localparam logic [9:0] K_GG = 10'd686;
   localparam logic [9:0] K_GB = 10'd168;
   localparam logic [9:0] K_BR = 10'd272;
   localparam logic [9:0] K_BG = 10'd534;
   localparam logic [9:0] K_BB = 10'd131;

   // largest sum is 1351 * 255 = 344505, fits 19 bits
   localparam int SUM_W = 19;
   // floor(x / 1000) == (x * 268436) >> 28, exact for x below 493447
   localparam logic [18:0] DIV_RECIP = 19'd268436;
   localparam int DIV_SHIFT = 28;
   localparam int PROD_W    = 38;
   localparam int QUO_W     = 10;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef enum logic [1:0] {
      CMD_PASS  = 2'd0,
      CMD_SEPIA = 2'd1,
      CMD_STORE = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      pixel_type    pix;
   } cmd_type;

   typedef enum logic [1:0] {
      RK_PIX   = 2'd0,
      RK_SEPIA = 2'd1,
      RK_MEM   = 2'd2
   } res_kind_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sums_type;

   function automatic logic [SUM_W-1:0] sepia_sum(pixel_type p, logic [9:0] kr,
                                                  logic [9:0] kg, logic [9:0] kb);
      logic [SUM_W:0] acc;
      acc = (SUM_W+1)'(kr) * (SUM_W+1)'(p.red)
          + (SUM_W+1)'(kg) * (SUM_W+1)'(p.green)
          + (SUM_W+1)'(kb) * (SUM_W+1)'(p.blue);
      return acc[SUM_W-1:0];
   endfunction

   function automatic logic [7:0] sepia_div(logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] prod;
      logic [QUO_W-1:0]  q;
      prod = PROD_W'(s) * PROD_W'(DIV_RECIP);
      q    = prod[DIV_SHIFT +: QUO_W];
      return (q > QUO_W'(255)) ? 8'd255 : q[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psr_fifo.sv =====
// ---------------------------------------------------------------------------
// psr_fifo : small synchronous queue
// Register-based FIFO with head shown combinationally and an occupancy count.
// ---------------------------------------------------------------------------
`default_nettype none

module psr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [WIDTH-1:0]               wr_data,
   output logic                                full,
   input  wire logic                           pop,
   output logic [WIDTH-1:0]                    rd_data,
   output logic                                empty,
   output logic [$clog2(DEPTH+1)-1:0]          count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/psr_front.sv =====
// ---------------------------------------------------------------------------
// psr_front : item intake and classification
// Turns each accepted pixel into a command for the back end and keeps the
// column position of the row being mirrored.
// ---------------------------------------------------------------------------
`default_nettype none

module psr_front import psr_pkg::*; #(
   parameter int MAX_ROW_WIDTH = 64,
   parameter int IDX_W         = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       mode,
   input  wire logic [6:0]       row_width,
   input  wire logic             req_push,
   input  wire req_type          req_data,
   input  wire logic             cmd_full,
   output logic                  cmd_push,
   output cmd_type               cmd_data,
   output logic [IDX_W-1:0]      cmd_idx
);

   logic [IDX_W-1:0] col_ff, col_in;
   logic [6:0]       width_eff;
   logic             row_end;

   always_comb begin
      if (row_width == 7'd0) begin
         width_eff = 7'd1;
      end else if (row_width > 7'(MAX_ROW_WIDTH)) begin
         width_eff = 7'(MAX_ROW_WIDTH);
      end else begin
         width_eff = row_width;
      end
   end

   // a shrunk width can end the row early
   assign row_end = (7'(col_ff) + 7'd1) >= width_eff;

   assign cmd_push          = req_push && !cmd_full;
   assign cmd_idx           = col_ff;

   always_comb begin
      col_in             = col_ff;
      cmd_data.pix.red   = req_data.in_red;
      cmd_data.pix.green = req_data.in_green;
      cmd_data.pix.blue  = req_data.in_blue;
      unique case (mode)
         MODE_SEPIA: begin
            cmd_data.kind = CMD_SEPIA;
         end
         MODE_MIRROR: begin
            cmd_data.kind = row_end ? CMD_FLUSH : CMD_STORE;
            if (cmd_push) begin
               col_in = row_end ? '0 : col_ff + IDX_W'(1);
            end
         end
         default: begin
            cmd_data.kind = CMD_PASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/psr_back.sv =====
// ---------------------------------------------------------------------------
// psr_back : command execution
// Holds the row memory, computes sepia tone in two stages and plays a row
// back in reverse into the result queue, one pixel per cycle while it has room.
// ---------------------------------------------------------------------------
`default_nettype none

module psr_back import psr_pkg::*; #(
   parameter int MAX_ROW_WIDTH = 64,
   parameter int IDX_W         = 6,
   parameter int OUT_CNT_W     = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_empty,
   input  wire cmd_type              cmd_data,
   input  wire logic [IDX_W-1:0]     cmd_idx,
   output logic                      cmd_pop,
   input  wire logic [OUT_CNT_W-1:0] out_count,
   output logic                      out_push,
   output rsp_type                   out_data,
   output logic                      flushing
);

   localparam int ROOM_W = OUT_CNT_W + 1;

   typedef enum logic [1:0] {
      ST_CMD   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] flush_addr_ff, flush_addr_in;

   logic             s1_valid_ff, s1_valid_in;
   res_kind_type     s1_kind_ff, s1_kind_in;
   pixel_type        s1_pix_ff;
   logic             s1_last_ff, s1_last_in;
   sums_type         s1_sum_ff, s1_sum_in;

   pixel_type        row_mem [MAX_ROW_WIDTH];
   pixel_type        rd_ff;
   logic             mem_we;
   logic             room;

   // count in-flight stage so the queue can never overflow
   assign room = (ROOM_W'(out_count) + ROOM_W'(s1_valid_ff)) < ROOM_W'(OUT_DEPTH);
   assign flushing = (state_ff == ST_FLUSH);

   assign s1_sum_in = {sepia_sum(cmd_data.pix, K_RR, K_RG, K_RB),
                       sepia_sum(cmd_data.pix, K_GR, K_GG, K_GB),
                       sepia_sum(cmd_data.pix, K_BR, K_BG, K_BB)};

   always_comb begin
      state_in      = state_ff;
      flush_addr_in = flush_addr_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      s1_valid_in   = 1'b0;
      s1_kind_in    = RK_PIX;
      s1_last_in    = 1'b1;
      if (room) begin
         unique case (state_ff)
            ST_CMD: begin
               if (!cmd_empty) begin
                  cmd_pop = 1'b1;
                  case (cmd_data.kind)
                     CMD_PASS: begin
                        s1_valid_in = 1'b1;
                     end
                     CMD_SEPIA: begin
                        s1_valid_in = 1'b1;
                        s1_kind_in  = RK_SEPIA;
                     end
                     CMD_STORE: begin
                        mem_we = 1'b1;
                     end
                     CMD_FLUSH: begin
                        // newest pixel goes out first, straight from the item
                        mem_we      = 1'b1;
                        s1_valid_in = 1'b1;
                        s1_last_in  = (cmd_idx == '0);
                        if (cmd_idx != '0) begin
                           state_in      = ST_FLUSH;
                           flush_addr_in = cmd_idx - IDX_W'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_FLUSH: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = RK_MEM;
               s1_last_in  = (flush_addr_ff == '0);
               if (flush_addr_ff == '0) begin
                  state_in = ST_CMD;
               end else begin
                  flush_addr_in = flush_addr_ff - IDX_W'(1);
               end
            end
            default: begin
               state_in = ST_CMD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CMD;
         flush_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flush_addr_ff <= flush_addr_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_pix_ff  <= cmd_data.pix;
      s1_last_ff <= s1_last_in;
      s1_sum_ff  <= s1_sum_in;
   end

   // row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[cmd_idx] <= cmd_data.pix;
      end
      rd_ff <= row_mem[flush_addr_ff];
   end

   assign out_push = s1_valid_ff;

   always_comb begin
      out_data.last_of_run = s1_last_ff;
      case (s1_kind_ff)
         RK_SEPIA: begin
            out_data.out_red   = sepia_div(s1_sum_ff.red);
            out_data.out_green = sepia_div(s1_sum_ff.green);
            out_data.out_blue  = sepia_div(s1_sum_ff.blue);
         end
         RK_MEM: begin
            out_data.out_red   = rd_ff.red;
            out_data.out_green = rd_ff.green;
            out_data.out_blue  = rd_ff.blue;
         end
         default: begin
            out_data.out_red   = s1_pix_ff.red;
            out_data.out_green = s1_pix_ff.green;
            out_data.out_blue  = s1_pix_ff.blue;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_sepia_or_row_flip.sv =====
// ---------------------------------------------------------------------------
// pixel_sepia_or_row_flip : sepia tone / horizontal mirror pixel stream block
// One RGB pixel per item in; pass-through, sepia or row-reversed pixels out.
// ---------------------------------------------------------------------------
// Usage
//   Input queue (req_): drive req_data and req_push; the item is taken on a
//   clock edge with req_push high and req_full low. Result queue (rsp_): the
//   oldest result sits on rsp_data while rsp_empty is low; rsp_pop takes it.
//   CSR port (csr_): mode at 0x0, row_width at 0x4; write only while idle.
// Timing
//   Pass-through and sepia: 1 item per cycle sustained while the result queue
//   drains; results pass the command queue, sepia stage and result queue.
//   Mirror: non-final pixels are only stored and give no result. The final
//   pixel of a row of W pixels holds the back end while the row plays back,
//   one pixel per cycle from the row memory's single read port, given room.
//   Front end keeps taking items into a 4-deep command queue meanwhile.
// Reset
//   Queues empty, column position 0, mode pass-through, row_width 64. Row
//   memory is not cleared; only entries of the current row are read back.
// Stall
//   A stalled consumer fills the 4-deep result queue, then the back end
//   stops issuing, then the command queue fills and req_full rises.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_sepia_or_row_flip import psr_pkg::*; #(
   parameter int MAX_ROW_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item queue
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   // result queue
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IDX_W     = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
   localparam int CMD_W     = $bits(cmd_type) + IDX_W;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

   // register index taken from paddr[2]
   localparam logic REG_MODE      = 1'b0;
   localparam logic REG_ROW_WIDTH = 1'b1;

   logic [1:0] mode_ff, mode_in;
   logic [6:0] row_width_ff, row_width_in;
   logic       csr_wr;

   // ---- configuration registers ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in      = mode_ff;
      row_width_in = row_width_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MODE:      mode_in      = csr_pwdata[1:0];
            REG_ROW_WIDTH: row_width_in = csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MODE:      csr_prdata = 32'(mode_ff);
         REG_ROW_WIDTH: csr_prdata = 32'(row_width_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PASS;
         row_width_ff <= 7'd64;
      end else begin
         mode_ff      <= mode_in;
         row_width_ff <= row_width_in;
      end
   end

   // ---- front end: intake and classification ----
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type          front_cmd, back_cmd;
   logic [IDX_W-1:0] front_idx, back_idx;
   logic [CMD_W-1:0] cmd_wr, cmd_rd;

   psr_front #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .IDX_W         (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .row_width (row_width_ff),
      .req_push  (req_push),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (front_cmd),
      .cmd_idx   (front_idx)
   );

   assign req_full = cmd_full;
   assign cmd_wr   = {front_idx, front_cmd};
   assign back_cmd = cmd_rd[$bits(cmd_type)-1:0];
   assign back_idx = cmd_rd[CMD_W-1 -: IDX_W];

   // command queue decouples intake from execution
   psr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty),
      .count   ()
   );

   // ---- back end: execution ----
   logic                 out_push, out_full, flushing;
   rsp_type              out_data;
   logic [OUT_CNT_W-1:0] out_count;

   psr_back #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .IDX_W         (IDX_W),
      .OUT_CNT_W     (OUT_CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_idx   (back_idx),
      .cmd_pop   (cmd_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_data),
      .flushing  (flushing)
   );

   // result queue; back end only issues when it has room
   psr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty),
      .count   (out_count)
   );

   // ---- assertions ----
   a_out_no_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue pushed while full");

   a_flush_holds_queue : assert property (@(posedge clock) disable iff (reset)
      flushing |-> !cmd_pop)
      else $error("command popped during row playback");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

endmodule

`default_nettype wire

// ===== bench/tb_pixel_sepia_or_row_flip.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pixel_sepia_or_row_flip : self-checking bench for the sepia / row-flip block
// Pushes pixels through the input queue under several mode and row-width
// settings, predicts every result pixel in a local model of the block and
// compares each popped result field by field, in order, against that model.
// ---------------------------------------------------------------------------
module tb_pixel_sepia_or_row_flip;
   import psr_pkg::*;

   // spare mode code: the block treats it as pass-through
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // register byte addresses on the csr port
   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_ROW_WIDTH = 3'd4;

   localparam int MAX_ROW      = 64;
   localparam int SETTLE_WAIT  = 16;    // covers queued mirror stores with no result
   localparam int LONG_STALL   = 200;   // receiver hold-off, long enough to fill both queues
   localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving before we give up
   localparam int REPORT_LIMIT = 10;

   // sepia matrix in thousandths, one row per output channel
   localparam int unsigned SEP_RR = 393, SEP_RG = 769, SEP_RB = 189;
   localparam int unsigned SEP_GR = 349, SEP_GG = 686, SEP_GB = 168;
   localparam int unsigned SEP_BR = 272, SEP_BG = 534, SEP_BB = 131;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   req_type     req_data    = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop     = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_sepia_or_row_flip uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // local copy of the block's registers and row state
   logic [1:0] cur_mode      = MODE_PASS;
   logic [6:0] cur_row_width = 7'd64;
   req_type    row_buf [MAX_ROW];
   int         col_pos       = 0;

   rsp_type    pending_pixels [$];  // predicted results, oldest first
   int         bad_pixels    = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         stall_left    = 0;   // set by the stimulus, counted down by the receiver
   int         quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------
   function automatic logic [7:0] sepia_tone(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             int unsigned kr, int unsigned kg,
                                             int unsigned kb);
      int unsigned v;
      v = (kr * r + kg * g + kb * b) / 1000;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // works out the result pixels caused by one accepted item and queues them
   function automatic void forecast_pixels(req_type px);
      int      w;
      int      idx;
      rsp_type res;
      case (cur_mode)
         MODE_SEPIA: begin
            res.out_red     = sepia_tone(px.in_red, px.in_green, px.in_blue,
                                         SEP_RR, SEP_RG, SEP_RB);
            res.out_green   = sepia_tone(px.in_red, px.in_green, px.in_blue,
                                         SEP_GR, SEP_GG, SEP_GB);
            res.out_blue    = sepia_tone(px.in_red, px.in_green, px.in_blue,
                                         SEP_BR, SEP_BG, SEP_BB);
            res.last_of_run = 1'b1;
            pending_pixels.push_back(res);
         end
         MODE_MIRROR: begin
            // width 0 acts as 1, anything past the buffer as a full buffer
            w = int'(cur_row_width);
            if (w < 1) w = 1;
            if (w > MAX_ROW) w = MAX_ROW;
            idx = col_pos;
            if (idx >= MAX_ROW) idx = MAX_ROW - 1;
            row_buf[idx] = px;
            if (idx + 1 < w) begin
               col_pos = idx + 1;
            end else begin
               // row done (or width shrunk under it): play it back reversed
               for (int k = idx; k >= 0; k--) begin
                  res.out_red     = row_buf[k].in_red;
                  res.out_green   = row_buf[k].in_green;
                  res.out_blue    = row_buf[k].in_blue;
                  res.last_of_run = (k == 0);
                  pending_pixels.push_back(res);
               end
               col_pos = 0;
            end
         end
         default: begin
            // pass-through, spare code included
            res.out_red     = px.in_red;
            res.out_green   = px.in_green;
            res.out_blue    = px.in_blue;
            res.last_of_run = 1'b1;
            pending_pixels.push_back(res);
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result side: random pops, plus a long hold-off on request
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // each popped item against the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            bad_pixels++;
            if (bad_pixels <= REPORT_LIMIT)
               $display("%0t: result with nothing pending: r=%0d g=%0d b=%0d last=%0b",
                        $realtime, rsp_data.out_red, rsp_data.out_green,
                        rsp_data.out_blue, rsp_data.last_of_run);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green
                || rsp_data.out_blue !== want.out_blue
                || rsp_data.last_of_run !== want.last_of_run) begin
               bad_pixels++;
               if (bad_pixels <= REPORT_LIMIT)
                  $display("%0t: mismatch: want r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                           $realtime, want.out_red, want.out_green, want.out_blue,
                           want.last_of_run, rsp_data.out_red, rsp_data.out_green,
                           rsp_data.out_blue, rsp_data.last_of_run);
            end
         end
      end
   end

   // watchdog: nothing moving on either queue for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // offers one item; push stays high afterwards so back-to-back items
   // need no gap. settle() drops it.
   task automatic push_pixel(input req_type px);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_full);
      forecast_pixels(px);
   endtask

   // stop offering, drain every predicted result, then let queued
   // mirror stores (which return nothing) work through the block
   task automatic settle();
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (addr)
         REG_MODE:      cur_mode      = value[1:0];
         REG_ROW_WIDTH: cur_row_width = value[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [6:0] width);
      settle();
      csr_write(REG_MODE, 32'(mode));
      csr_write(REG_ROW_WIDTH, 32'(width));
   endtask

   // channels lean towards 0 and 255 now and then so the clamp gets exercised
   function automatic logic [7:0] rand_channel();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic req_type rand_pixel();
      req_type px;
      px.in_red   = rand_channel();
      px.in_green = rand_channel();
      px.in_blue  = rand_channel();
      return px;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_pass_modes();
      set_config(MODE_PASS, 7'd64);
      push_pixel({8'd0, 8'd0, 8'd0});
      push_pixel({8'd255, 8'd255, 8'd255});
      push_pixel({8'h55, 8'hAA, 8'h55});
      push_pixel({8'hAA, 8'h55, 8'hAA});
      push_pixel({8'h01, 8'h80, 8'h7F});
      // spare mode code behaves as pass-through
      set_config(MODE_SPARE, 7'd64);
      push_pixel({8'h12, 8'hFE, 8'h00});
      push_pixel({8'hFF, 8'h00, 8'h81});
   endtask

   task automatic test_sepia();
      set_config(MODE_SEPIA, 7'd64);
      push_pixel({8'd0, 8'd0, 8'd0});
      push_pixel({8'd255, 8'd255, 8'd255});   // red and green clamp, blue does not
      push_pixel({8'd255, 8'd0, 8'd0});
      push_pixel({8'd0, 8'd255, 8'd0});
      push_pixel({8'd0, 8'd0, 8'd255});
      push_pixel({8'd1, 8'd1, 8'd1});          // truncation of small sums
   endtask

   task automatic test_mirror_rows();
      // one-pixel rows: each item comes straight back
      set_config(MODE_MIRROR, 7'd1);
      push_pixel({8'd10, 8'd20, 8'd30});
      push_pixel({8'd255, 8'd0, 8'd255});
      // zero width acts as one
      set_config(MODE_MIRROR, 7'd0);
      push_pixel({8'd7, 8'd8, 8'd9});
      set_config(MODE_MIRROR, 7'd3);
      push_pixel({8'd1, 8'd2, 8'd3});
      push_pixel({8'd4, 8'd5, 8'd6});
      push_pixel({8'd7, 8'd8, 8'd9});
   endtask

   // a partial row survives a spell in pass-through
   task automatic test_mirror_mode_switch();
      set_config(MODE_MIRROR, 7'd4);
      push_pixel({8'd11, 8'd12, 8'd13});
      push_pixel({8'd21, 8'd22, 8'd23});
      set_config(MODE_PASS, 7'd4);
      push_pixel({8'd99, 8'd98, 8'd97});
      set_config(MODE_MIRROR, 7'd4);
      push_pixel({8'd31, 8'd32, 8'd33});
      push_pixel({8'd41, 8'd42, 8'd43});
   endtask

   // width cut below the stored count: the next pixel closes the row
   task automatic test_mirror_shrink();
      set_config(MODE_MIRROR, 7'd5);
      push_pixel({8'd50, 8'd51, 8'd52});
      push_pixel({8'd60, 8'd61, 8'd62});
      push_pixel({8'd70, 8'd71, 8'd72});
      set_config(MODE_MIRROR, 7'd2);
      push_pixel({8'd80, 8'd81, 8'd82});
   endtask

   // random runs of settings; mirror mostly gets whole rows with random
   // content, sometimes a ragged tail that the next setting has to live with
   task automatic test_random_stream(input int n_items, input int send_pct,
                                     input int recv_pct);
      int         sent;
      int         count;
      int         w;
      logic [1:0] mode;
      logic [6:0] width;
      sent = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0, 1:    mode = MODE_PASS;
            2:       mode = MODE_SPARE;
            3, 4, 5: mode = MODE_SEPIA;
            default: mode = MODE_MIRROR;
         endcase
         case ($urandom_range(19))
            0:          width = 7'd0;
            1:          width = 7'd64;
            2:          width = 7'($urandom_range(65, 127));
            3, 4, 5:    width = 7'($urandom_range(9, 63));
            default:    width = 7'($urandom_range(1, 8));
         endcase
         set_config(mode, width);
         w = (width == 0) ? 1 : (width > MAX_ROW) ? MAX_ROW : int'(width);
         if (mode == MODE_MIRROR) begin
            count = w * ((w > 8) ? 1 : $urandom_range(1, 4));
            if ($urandom_range(4) == 0) count += $urandom_range(0, w - 1);
         end else begin
            count = $urandom_range(4, 16);
         end
         repeat (count) push_pixel(rand_pixel());
         sent += count;
      end
   endtask

   // receiver holds off while the sender keeps offering: both queues fill
   // and req_full has to rise; then the sender waits for a full drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(MODE_MIRROR, 7'd8);
      stall_left = LONG_STALL;
      repeat (24) push_pixel(rand_pixel());
      set_config(MODE_SEPIA, 7'd8);
      stall_left = LONG_STALL;
      repeat (16) push_pixel(rand_pixel());
      settle();
      repeat (8) push_pixel(rand_pixel());
   endtask

   initial begin
      for (int i = 0; i < MAX_ROW; i++) row_buf[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // light sender gaps, heavy receiver gaps
      send_idle_pct = 11;
      recv_idle_pct = 86;
      test_pass_modes();
      test_sepia();
      test_mirror_rows();
      test_mirror_mode_switch();
      test_mirror_shrink();
      test_random_stream(95, 11, 86);
      // and the other way round
      test_random_stream(95, 86, 11);
      test_backpressure();
      // no gaps at all
      test_random_stream(90, 0, 0);

      settle();
      if (bad_pixels == 0 && pending_pixels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
